@@ src/dst_pkg.sv @@
// Package for the diffusion schedule terms block.
// Holds the fixed-point constants, sequencer states and serial unit types.
// Has no dependencies.
package dst_pkg;

    localparam int FRAC_BITS  = 31;
    localparam int RECIP_FRAC = 24;
    localparam int RECIP_TOP  = 2 * RECIP_FRAC + FRAC_BITS;
    localparam int DIV_STEPS  = RECIP_TOP + 1;
    localparam int DIV_W      = DIV_STEPS;
    localparam int MUL_STEPS  = 32;
    localparam int ROOT_STEPS = 32;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [31:0] ONE_FX     = 32'(64'd1 << FRAC_BITS);
    localparam logic [31:0] TINY_ALPHA = ONE_FX >> 16;
    localparam logic [31:0] SAT_32     = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_DIV,
        S_RPREP,
        S_ROOT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [DIV_W-1:0] n;
        logic [32:0]      rem;
        logic [63:0]      q;
    } t_div;

    typedef struct packed {
        logic [63:0] v;
        logic [35:0] rem;
        logic [31:0] root;
    } t_root;

endpackage

@@ src/diffusion_schedule_terms.sv @@
// Top level of the diffusion schedule terms block.
// Serial multipliers, restoring dividers and bit-pair square root units.
// Depends on dst_pkg.
//
// Channel  Direction  Handshake                 Payload
// input    in         i_in_valid / o_in_stall   i_beta, i_first_step
// output   out        o_out_valid / i_out_stall o_alpha ... o_alpha_zero
//
// The serial units take 32 multiply steps, 80 divide steps and
// 32 square root steps per item, with load states S_PREP and S_RPREP.
// One item is worked on at a time; the next is taken once the result is
// handed to the output register, which holds it while the output stalls.
// Reset sets the running product to 1.0 and empties the output register.
module diffusion_schedule_terms
    import dst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_beta,
    input  logic        i_first_step,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_alpha,
    output logic [31:0] o_cum_product,
    output logic [31:0] o_prev_cum_product,
    output logic [31:0] o_sqrt_recip_alpha,
    output logic [31:0] o_sqrt_cum_product,
    output logic [31:0] o_sqrt_one_minus_cum,
    output logic [31:0] o_posterior_var,
    output logic        o_alpha_zero
);

    function automatic t_div f_div_step(t_div s, logic [31:0] d);
        t_div        o;
        logic [32:0] r2;
        r2  = {s.rem[31:0], s.n[DIV_W-1]};
        o.n = {s.n[DIV_W-2:0], 1'b0};
        if (r2 >= {1'b0, d}) begin
            o.rem = r2 - {1'b0, d};
            o.q   = {s.q[62:0], 1'b1};
        end else begin
            o.rem = r2;
            o.q   = {s.q[62:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_root f_root_step(t_root s);
        t_root       o;
        logic [35:0] r2;
        logic [35:0] t;
        r2  = {s.rem[33:0], s.v[63:62]};
        t   = {2'b00, s.root, 2'b01};
        o.v = {s.v[61:0], 2'b00};
        if (r2 >= t) begin
            o.rem  = r2 - t;
            o.root = {s.root[30:0], 1'b1};
        end else begin
            o.rem  = r2;
            o.root = {s.root[30:0], 1'b0};
        end
        return o;
    endfunction

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [31:0]        r_rp;
    logic [31:0]        r_beta, r_alpha, r_prev, r_cum;
    logic [31:0]        r_mb1, r_mb2;
    logic [63:0]        r_acc1, r_acc2;
    t_div               r_d1, r_d2;
    t_root              r_q0, r_q1;
    logic [31:0]        r_scum, r_somc;
    logic               r_ovalid;

    logic [31:0]        beta_c, prev_c, cum_c, denom;
    logic [31:0]        pvar, srecip;

    assign beta_c = (i_beta > ONE_FX) ? ONE_FX : i_beta;
    assign prev_c = i_first_step ? ONE_FX : ((r_rp > ONE_FX) ? ONE_FX : r_rp);
    assign cum_c  = 32'(r_acc1 >> FRAC_BITS);
    assign denom  = ONE_FX - r_cum;

    assign pvar = (denom == 32'd0) ? 32'd0 :
                  ((r_d2.q > 64'(ONE_FX)) ? ONE_FX : r_d2.q[31:0]);
    assign srecip = (r_alpha == 32'd0) ? 32'd0 :
                    ((r_alpha <= TINY_ALPHA) ? SAT_32 : r_q0.root);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_MUL;
            end
            S_MUL: begin
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) n_state = S_PREP;
            end
            S_PREP: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_RPREP;
            end
            S_RPREP: n_state = S_ROOT;
            S_ROOT: begin
                if (r_cnt == CNT_W'(ROOT_STEPS - 1)) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || !i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp     <= ONE_FX;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (r_state == S_OUT && (!r_ovalid || !i_out_stall)) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_in_valid) begin
                        r_beta  <= beta_c;
                        r_alpha <= ONE_FX - beta_c;
                        r_prev  <= prev_c;
                        r_mb1   <= ONE_FX - beta_c;
                        r_mb2   <= ONE_FX - prev_c;
                        r_acc1  <= '0;
                        r_acc2  <= '0;
                    end
                end
                S_MUL: begin
                    r_cnt  <= r_cnt + 1'b1;
                    r_mb1  <= r_mb1 >> 1;
                    r_mb2  <= r_mb2 >> 1;
                    r_acc1 <= 64'(({1'b0, r_acc1}
                              + (r_mb1[0] ? {1'b0, r_prev, 32'd0} : 65'd0)) >> 1);
                    r_acc2 <= 64'(({1'b0, r_acc2}
                              + (r_mb2[0] ? {1'b0, r_beta, 32'd0} : 65'd0)) >> 1);
                end
                S_PREP: begin
                    r_cnt    <= '0;
                    r_cum    <= cum_c;
                    r_rp     <= cum_c;
                    r_d1.n   <= DIV_W'(1) << RECIP_TOP;
                    r_d1.rem <= '0;
                    r_d1.q   <= '0;
                    r_d2.n   <= DIV_W'(r_acc2);
                    r_d2.rem <= '0;
                    r_d2.q   <= '0;
                    r_q0.v    <= 64'(cum_c) << FRAC_BITS;
                    r_q0.rem  <= '0;
                    r_q0.root <= '0;
                    r_q1.v    <= 64'(ONE_FX - cum_c) << FRAC_BITS;
                    r_q1.rem  <= '0;
                    r_q1.root <= '0;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    r_d1  <= f_div_step(r_d1, r_alpha);
                    r_d2  <= f_div_step(r_d2, denom);
                    if (r_cnt < CNT_W'(ROOT_STEPS)) begin
                        r_q0 <= f_root_step(r_q0);
                        r_q1 <= f_root_step(r_q1);
                    end
                end
                S_RPREP: begin
                    r_cnt     <= '0;
                    r_scum    <= r_q0.root;
                    r_somc    <= r_q1.root;
                    r_q0.v    <= r_d1.q;
                    r_q0.rem  <= '0;
                    r_q0.root <= '0;
                end
                S_ROOT: begin
                    r_cnt <= r_cnt + 1'b1;
                    r_q0  <= f_root_step(r_q0);
                end
                S_OUT: begin
                    if (!r_ovalid || !i_out_stall) begin
                        o_alpha              <= r_alpha;
                        o_cum_product        <= r_cum;
                        o_prev_cum_product   <= r_prev;
                        o_sqrt_recip_alpha   <= srecip;
                        o_sqrt_cum_product   <= r_scum;
                        o_sqrt_one_minus_cum <= r_somc;
                        o_posterior_var      <= pvar;
                        o_alpha_zero         <= (r_alpha == 32'd0);
                    end
                end
                default: r_cnt <= '0;
            endcase
        end
    end

endmodule

@@ verif/tb_diffusion_schedule_terms.sv @@
// Testbench for the diffusion schedule terms block: drives beta items, predicts
// every schedule term in fixed point and checks each result item in order.
// Depends on dst_pkg and diffusion_schedule_terms.
typedef struct packed {
    logic [31:0] alpha, cum, prev, srecip, scum, somc, pvar;
    logic        azero;
} t_terms;

class schedule_scoreboard;
    t_terms       pending[$];
    logic [63:0]  product;
    int           mismatches;

    function new();
        product = 64'(dst_pkg::ONE_FX);
        mismatches = 0;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function void note_beta(logic [31:0] beta_in, logic first);
        logic [63:0] one, beta, alpha, prev, cum, sr, denom, pv;
        logic [127:0] quot;
        t_terms t;
        one = 64'(dst_pkg::ONE_FX);
        beta = (64'(beta_in) > one) ? one : 64'(beta_in);
        alpha = one - beta;
        prev = first ? one : product;
        if (prev > one) prev = one;
        cum = (prev * alpha) >> dst_pkg::FRAC_BITS;
        product = cum;
        if (alpha == 0) begin
            sr = 0;
        end else if ((alpha << 16) <= one) begin
            sr = 64'hFFFF_FFFF;
        end else begin
            quot = (128'd1 << dst_pkg::RECIP_TOP) / 128'(alpha);
            sr = int_sqrt(quot[63:0]);
            if (sr > 64'hFFFF_FFFF) sr = 64'hFFFF_FFFF;
        end
        denom = one - cum;
        if (denom == 0) begin
            pv = 0;
        end else begin
            pv = (beta * (one - prev)) / denom;
            if (pv > one) pv = one;
        end
        t.alpha = alpha[31:0];
        t.cum = cum[31:0];
        t.prev = prev[31:0];
        t.srecip = sr[31:0];
        t.scum = 32'(int_sqrt(cum << dst_pkg::FRAC_BITS));
        t.somc = 32'(int_sqrt((one - cum) << dst_pkg::FRAC_BITS));
        t.pvar = pv[31:0];
        t.azero = (alpha == 0);
        pending.push_back(t);
    endfunction

    function void check_terms(t_terms got);
        t_terms e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Result item arrived with none expected.");
            return;
        end
        e = pending.pop_front();
        if (got !== e) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Mismatch: expected %h %h %h %h %h %h %h %b",
                         e.alpha, e.cum, e.prev, e.srecip, e.scum, e.somc, e.pvar,
                         e.azero);
                $display("          got      %h %h %h %h %h %h %h %b",
                         got.alpha, got.cum, got.prev, got.srecip,
                         got.scum, got.somc, got.pvar, got.azero);
            end
        end
    endfunction
endclass

module tb_diffusion_schedule_terms
    import dst_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic        i_clk, i_rst_n, i_in_valid, o_in_stall, i_first_step;
    logic [31:0] i_beta;
    logic        o_out_valid, i_out_stall, o_alpha_zero;
    logic [31:0] o_alpha, o_cum_product, o_prev_cum_product, o_sqrt_recip_alpha;
    logic [31:0] o_sqrt_cum_product, o_sqrt_one_minus_cum, o_posterior_var;

    schedule_scoreboard board;
    int send_idle_pct, recv_stall_pct, quiet_cycles;

    diffusion_schedule_terms dut (.*);

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_terms got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.alpha = o_alpha;
            got.cum = o_cum_product;
            got.prev = o_prev_cum_product;
            got.srecip = o_sqrt_recip_alpha;
            got.scum = o_sqrt_cum_product;
            got.somc = o_sqrt_one_minus_cum;
            got.pvar = o_posterior_var;
            got.azero = o_alpha_zero;
            board.check_terms(got);
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_diffusion_schedule_terms: FAIL");
            $finish;
        end
    end

    task automatic send_beta(logic [31:0] beta, logic first);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_beta <= beta;
        i_first_step <= first;
        do @(posedge i_clk); while (o_in_stall);
        board.note_beta(beta, first);
    endtask

    function automatic logic [31:0] random_beta();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(32'h0100_0000);
            2: return ONE_FX - $urandom_range(32'hFFFF);
            3: return $urandom_range(ONE_FX);
            default: return $urandom_range(32'h0400_0000);
        endcase
    endfunction

    initial begin
        board = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet_cycles = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_beta = 0;
        i_first_step = 0;
        i_out_stall = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_beta(32'd0, 1'b0);
        send_beta(32'd1, 1'b0);
        send_beta(ONE_FX, 1'b0);
        send_beta(32'hFFFF_FFFF, 1'b1);
        send_beta(ONE_FX + 1, 1'b0);
        send_beta(ONE_FX - 1, 1'b1);
        send_beta(ONE_FX - TINY_ALPHA, 1'b1);
        send_beta(ONE_FX - TINY_ALPHA - 1, 1'b1);
        send_beta(ONE_FX - TINY_ALPHA + 1, 1'b1);
        send_beta(32'h4000_0000, 1'b1);
        send_beta(32'h4000_0000, 1'b0);
        send_beta(32'h5555_5555, 1'b0);
        send_beta(32'hAAAA_AAAA, 1'b0);
        send_beta(32'h0000_0000, 1'b1);
        send_beta(32'h0000_0010, 1'b0);
        send_beta(32'h7FFF_FFFF, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 53 : 13) : 0;
            recv_stall_pct = (phase == 2) ? 53 : ((phase == 3) ? 13 : 0);
            for (int k = 0; k < 135; k++)
                send_beta(random_beta(), ($urandom_range(19) == 0));
            if (phase == 1) begin
                i_in_valid <= 1'b0;
                while (board.pending.size() != 0) @(posedge i_clk);
            end
        end

        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("tb_diffusion_schedule_terms: PASS");
        else
            $display("tb_diffusion_schedule_terms: FAIL");
        $finish;
    end
endmodule

@@ files.f @@
src/dst_pkg.sv
src/diffusion_schedule_terms.sv
verif/tb_diffusion_schedule_terms.sv
